### rtl/ppwm_pkg.sv
// Shared types and constants for the probed pulse width meter.
// No dependencies; used by the interfaces and every module of the block.
package ppwm_pkg;

   localparam int CMD_W    = 3;
   localparam int PORT_W   = 2;
   localparam int BIT_W    = 3;
   localparam int CHIDX_W  = 2;
   localparam int SNAP_W   = 32;
   localparam int TICKS_W  = 32;
   localparam int MASK_W   = 4;

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   // decoded operation kinds carried through the queue
   localparam logic [2:0] KIND_NOP    = 3'd0;
   localparam logic [2:0] KIND_SAMPLE = 3'd1;
   localparam logic [2:0] KIND_SET    = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_FIND   = 3'd4;
   localparam logic [2:0] KIND_READ   = 3'd5;

   typedef struct packed {
      logic [2:0]         kind;
      logic               arg_ok;   // port in range for set, channel in range for read
      logic [PORT_W-1:0]  port_index;
      logic [BIT_W-1:0]   bit_index;
      logic [CHIDX_W-1:0] channel_index;
      logic [SNAP_W-1:0]  port_snapshot;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

endpackage

### rtl/ppwm_req_if.sv
// Request channel of the pulse width meter: valid/ready plus command payload.
// Depends on ppwm_pkg.
interface ppwm_req_if;
   logic                          valid;
   logic                          ready;
   logic [ppwm_pkg::CMD_W-1:0]    command;
   logic [ppwm_pkg::PORT_W-1:0]   port_index;
   logic [ppwm_pkg::BIT_W-1:0]    bit_index;
   logic [ppwm_pkg::CHIDX_W-1:0]  channel_index;
   logic [ppwm_pkg::SNAP_W-1:0]   port_snapshot;

   modport source (output valid, command, port_index, bit_index, channel_index,
                   port_snapshot, input ready);
   modport sink (input valid, command, port_index, bit_index, channel_index,
                 port_snapshot, output ready);
endinterface

### rtl/ppwm_rsp_if.sv
// Response channel of the pulse width meter: valid/ready plus result payload.
// Depends on ppwm_pkg.
interface ppwm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [ppwm_pkg::CHIDX_W-1:0]  channel;
   logic [ppwm_pkg::TICKS_W-1:0]  high_ticks;
   logic [ppwm_pkg::TICKS_W-1:0]  low_ticks;
   logic [ppwm_pkg::MASK_W-1:0]   rise_mask;
   logic [ppwm_pkg::MASK_W-1:0]   fall_mask;

   modport source (output valid, ok, channel, high_ticks, low_ticks, rise_mask,
                   fall_mask, input ready);
   modport sink (input valid, ok, channel, high_ticks, low_ticks, rise_mask,
                 fall_mask, output ready);
endinterface

### rtl/ppwm_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
// Depends on ppwm_pkg and ppwm_req_if.
module ppwm_front #(
   parameter int CHANNELS = 4,
   parameter int PORTS    = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   ppwm_req_if.sink                 req_ch,
   output ppwm_pkg::queue_head_type head,
   input  logic                     pop
);

   ppwm_pkg::op_type entry_ff [2];
   ppwm_pkg::op_type entry_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   ppwm_pkg::op_type decoded;
   logic             push;

   always_comb begin
      decoded.port_index    = req_ch.port_index;
      decoded.bit_index     = req_ch.bit_index;
      decoded.channel_index = req_ch.channel_index;
      decoded.port_snapshot = req_ch.port_snapshot;
      decoded.arg_ok        = 1'b0;
      case (req_ch.command)
         ppwm_pkg::CMD_SAMPLE: begin
            decoded.kind = ppwm_pkg::KIND_SAMPLE;
         end
         ppwm_pkg::CMD_SET: begin
            decoded.kind   = ppwm_pkg::KIND_SET;
            decoded.arg_ok = (32'(req_ch.port_index) < PORTS);
         end
         ppwm_pkg::CMD_DELETE: begin
            decoded.kind = ppwm_pkg::KIND_DELETE;
         end
         ppwm_pkg::CMD_FIND: begin
            decoded.kind = ppwm_pkg::KIND_FIND;
         end
         ppwm_pkg::CMD_READ: begin
            decoded.kind   = ppwm_pkg::KIND_READ;
            decoded.arg_ok = (32'(req_ch.channel_index) < CHANNELS);
         end
         default: begin
            decoded.kind = ppwm_pkg::KIND_NOP;
         end
      endcase
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;

   assign head.valid = (count_ff != 2'd0);
   assign head.op    = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = decoded;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/ppwm_back.sv
// Back end: probe table, per-channel edge timers and the registered response.
// Depends on ppwm_pkg and ppwm_rsp_if.
module ppwm_back #(
   parameter int CHANNELS    = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ppwm_pkg::queue_head_type head,
   output logic                     pop,
   ppwm_rsp_if.source               rsp_ch
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                          used_ff  [CHANNELS];
   logic                          used_in  [CHANNELS];
   logic [ppwm_pkg::PORT_W-1:0]   port_ff  [CHANNELS];
   logic [ppwm_pkg::PORT_W-1:0]   port_in  [CHANNELS];
   logic [ppwm_pkg::BIT_W-1:0]    bit_ff   [CHANNELS];
   logic [ppwm_pkg::BIT_W-1:0]    bit_in   [CHANNELS];
   logic                          level_ff [CHANNELS];
   logic                          level_in [CHANNELS];
   logic [COUNT_WIDTH-1:0]        count_ff [CHANNELS];
   logic [COUNT_WIDTH-1:0]        count_in [CHANNELS];
   logic [COUNT_WIDTH-1:0]        high_ff  [CHANNELS];
   logic [COUNT_WIDTH-1:0]        high_in  [CHANNELS];
   logic [COUNT_WIDTH-1:0]        low_ff   [CHANNELS];
   logic [COUNT_WIDTH-1:0]        low_in   [CHANNELS];

   logic [COUNT_WIDTH-1:0]        elapsed  [CHANNELS];
   logic [CHANNELS-1:0]           lvl_now;
   logic [CHANNELS-1:0]           hit;
   logic [CHANNELS-1:0]           rise;
   logic [CHANNELS-1:0]           fall;
   logic [CH_W-1:0]               hit_idx;
   logic [CH_W-1:0]               free_idx;
   logic                          hit_any;
   logic                          free_any;
   logic [CH_W+1:0]               read_ext;
   logic [CH_W-1:0]               read_idx;

   logic                          res_ok;
   logic [CH_W-1:0]               res_chan;
   logic [COUNT_WIDTH-1:0]        res_high;
   logic [COUNT_WIDTH-1:0]        res_low;
   logic [CH_W+1:0]               res_chan_ext;
   logic [COUNT_WIDTH+ppwm_pkg::TICKS_W-1:0] res_high_ext;
   logic [COUNT_WIDTH+ppwm_pkg::TICKS_W-1:0] res_low_ext;
   logic [CHANNELS+ppwm_pkg::MASK_W-1:0]     rise_ext;
   logic [CHANNELS+ppwm_pkg::MASK_W-1:0]     fall_ext;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             ok_ff;
   logic [ppwm_pkg::CHIDX_W-1:0]     channel_ff;
   logic [ppwm_pkg::TICKS_W-1:0]     high_ticks_ff;
   logic [ppwm_pkg::TICKS_W-1:0]     low_ticks_ff;
   logic [ppwm_pkg::MASK_W-1:0]      rise_mask_ff;
   logic [ppwm_pkg::MASK_W-1:0]      fall_mask_ff;

   assign pop = head.valid && (!rsp_valid_ff || rsp_ch.ready);

   // per-channel level, saturated tick count and probe match
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         lvl_now[c] = head.op.port_snapshot[{port_ff[c], bit_ff[c]}];
         elapsed[c] = (count_ff[c] == COUNT_MAX) ? COUNT_MAX : count_ff[c] + 1'b1;
         hit[c]     = used_ff[c] && (port_ff[c] == head.op.port_index)
                      && (bit_ff[c] == head.op.bit_index);
         rise[c]    = used_ff[c] && lvl_now[c] && !level_ff[c];
         fall[c]    = used_ff[c] && !lvl_now[c] && level_ff[c];
      end
   end

   // lowest matching and lowest free channel
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (hit[c]) begin
            hit_idx = CH_W'(c);
         end
         if (!used_ff[c]) begin
            free_idx = CH_W'(c);
         end
      end
      hit_any  = |hit;
      free_any = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         free_any = free_any | !used_ff[c];
      end
   end

   assign read_ext = {{CH_W{1'b0}}, head.op.channel_index};
   assign read_idx = read_ext[CH_W-1:0];

   always_comb begin
      used_in  = used_ff;
      port_in  = port_ff;
      bit_in   = bit_ff;
      level_in = level_ff;
      count_in = count_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      res_ok   = 1'b0;
      res_chan = '0;
      res_high = '0;
      res_low  = '0;
      case (head.op.kind)
         ppwm_pkg::KIND_SAMPLE: begin
            res_ok = 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               if (used_ff[c]) begin
                  level_in[c] = lvl_now[c];
                  if (rise[c]) begin
                     low_in[c]   = elapsed[c];
                     count_in[c] = '0;
                  end else if (fall[c]) begin
                     high_in[c]  = elapsed[c];
                     count_in[c] = '0;
                  end else begin
                     count_in[c] = elapsed[c];
                  end
               end
            end
         end
         ppwm_pkg::KIND_SET: begin
            if (head.op.arg_ok && !hit_any && free_any) begin
               used_in[free_idx]  = 1'b1;
               port_in[free_idx]  = head.op.port_index;
               bit_in[free_idx]   = head.op.bit_index;
               level_in[free_idx] = 1'b0;
               count_in[free_idx] = '0;
               high_in[free_idx]  = '0;
               low_in[free_idx]   = '0;
               res_ok             = 1'b1;
               res_chan           = free_idx;
            end
         end
         ppwm_pkg::KIND_DELETE: begin
            if (hit_any) begin
               used_in[hit_idx] = 1'b0;
               res_ok           = 1'b1;
               res_chan         = hit_idx;
            end
         end
         ppwm_pkg::KIND_FIND: begin
            if (hit_any) begin
               res_ok   = 1'b1;
               res_chan = hit_idx;
            end
         end
         ppwm_pkg::KIND_READ: begin
            if (head.op.arg_ok) begin
               res_ok   = 1'b1;
               res_chan = read_idx;
               res_high = high_ff[read_idx];
               res_low  = low_ff[read_idx];
            end
         end
         default: begin
         end
      endcase
   end

   assign res_chan_ext = {2'b00, res_chan};
   assign res_high_ext = {{ppwm_pkg::TICKS_W{1'b0}}, res_high};
   assign res_low_ext  = {{ppwm_pkg::TICKS_W{1'b0}}, res_low};
   assign rise_ext     = {{ppwm_pkg::MASK_W{1'b0}},
                          (head.op.kind == ppwm_pkg::KIND_SAMPLE) ? rise : {CHANNELS{1'b0}}};
   assign fall_ext     = {{ppwm_pkg::MASK_W{1'b0}},
                          (head.op.kind == ppwm_pkg::KIND_SAMPLE) ? fall : {CHANNELS{1'b0}}};

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            used_ff[c]  <= 1'b0;
            port_ff[c]  <= '0;
            bit_ff[c]   <= '0;
            level_ff[c] <= 1'b0;
            count_ff[c] <= '0;
            high_ff[c]  <= '0;
            low_ff[c]   <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            used_ff  <= used_in;
            port_ff  <= port_in;
            bit_ff   <= bit_in;
            level_ff <= level_in;
            count_ff <= count_in;
            high_ff  <= high_in;
            low_ff   <= low_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ok_ff         <= res_ok;
         channel_ff    <= res_chan_ext[ppwm_pkg::CHIDX_W-1:0];
         high_ticks_ff <= res_high_ext[ppwm_pkg::TICKS_W-1:0];
         low_ticks_ff  <= res_low_ext[ppwm_pkg::TICKS_W-1:0];
         rise_mask_ff  <= rise_ext[ppwm_pkg::MASK_W-1:0];
         fall_mask_ff  <= fall_ext[ppwm_pkg::MASK_W-1:0];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ok         = ok_ff;
   assign rsp_ch.channel    = channel_ff;
   assign rsp_ch.high_ticks = high_ticks_ff;
   assign rsp_ch.low_ticks  = low_ticks_ff;
   assign rsp_ch.rise_mask  = rise_mask_ff;
   assign rsp_ch.fall_mask  = fall_mask_ff;

endmodule

### rtl/probed_pulse_width_meter_top.sv
// Multichannel logic probe with per-channel pulse width capture.
// Channels: req_ch (sink) takes one command per transfer: sample tick, set,
// delete or find probe, or read channel. rsp_ch (source) returns exactly one
// result per command, in order.
// A command is decoded into the queue and, once at the queue head, executed;
// its result is registered for rsp_ch. Throughput: one command per clock while
// rsp_ch is not stalled; every command, sample ticks included, is executed by
// the back end against its channel table. A two-entry queue sits between
// request decode and execution, and the response is held in an output
// register, so requests keep flowing while a result waits; if rsp_ch stalls,
// the queue fills and req_ch.ready drops once it holds two entries.
// Reset (synchronous, active high) unbinds all channels and clears levels,
// counts and stored durations; no initialization sweep, the block accepts
// commands as soon as reset is released.
// Depends on ppwm_pkg, ppwm_req_if, ppwm_rsp_if, ppwm_front and ppwm_back.
module probed_pulse_width_meter_top #(
   parameter int CHANNELS    = 4,
   parameter int PORTS       = 4,
   parameter int COUNT_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   ppwm_req_if.sink    req_ch,
   ppwm_rsp_if.source  rsp_ch
);

   ppwm_pkg::queue_head_type head;
   logic                     pop;

   ppwm_front #(
      .CHANNELS (CHANNELS),
      .PORTS    (PORTS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   ppwm_back #(
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

### tb/sv/tb_top.sv
// Testbench for probed_pulse_width_meter_top: a directed table, then ~600 random commands.
// A local model of the probe table and pulse counters checks every result transfer.
// Depends on ppwm_pkg, ppwm_req_if, ppwm_rsp_if and the RTL under rtl/.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH          = 4;
   localparam int RANDOM_ITEMS = 600;
   localparam int IDLE_MAX     = 12;
   localparam int DRAIN_CYCLES = 16;

   // codes the block must treat as no-ops
   localparam logic [ppwm_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
   localparam logic [ppwm_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [ppwm_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

   typedef struct packed {
      logic [ppwm_pkg::CMD_W-1:0]   command;
      logic [ppwm_pkg::PORT_W-1:0]  port_index;
      logic [ppwm_pkg::BIT_W-1:0]   bit_index;
      logic [ppwm_pkg::CHIDX_W-1:0] channel_index;
      logic [ppwm_pkg::SNAP_W-1:0]  port_snapshot;
   } probe_cmd_type;

   typedef struct packed {
      logic                         ok;
      logic [ppwm_pkg::CHIDX_W-1:0] channel;
      logic [ppwm_pkg::TICKS_W-1:0] high_ticks;
      logic [ppwm_pkg::TICKS_W-1:0] low_ticks;
      logic [ppwm_pkg::MASK_W-1:0]  rise_mask;
      logic [ppwm_pkg::MASK_W-1:0]  fall_mask;
   } probe_rsp_type;

   typedef struct packed {
      probe_cmd_type cmd;
      logic          fixed;   // expected result typed in below
      probe_rsp_type rsp;
   } script_row_type;

   logic clock;
   logic reset;

   ppwm_req_if req_ch();
   ppwm_rsp_if rsp_ch();

   probed_pulse_width_meter_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // probe table and pulse counters as the block should hold them
   logic                         chan_bound [NCH] = '{default: '0};
   logic [ppwm_pkg::PORT_W-1:0]  chan_port  [NCH] = '{default: '0};
   logic [ppwm_pkg::BIT_W-1:0]   chan_bit   [NCH] = '{default: '0};
   logic                         chan_level [NCH] = '{default: '0};
   logic [ppwm_pkg::TICKS_W-1:0] chan_count [NCH] = '{default: '0};
   logic [ppwm_pkg::TICKS_W-1:0] chan_high  [NCH] = '{default: '0};
   logic [ppwm_pkg::TICKS_W-1:0] chan_low   [NCH] = '{default: '0};

   probe_rsp_type  pending_rsp[$];
   script_row_type script[$];
   logic [ppwm_pkg::SNAP_W-1:0] wave = '0;
   int fail_count    = 0;
   int send_gap_max  = IDLE_MAX;
   int rsp_stall_max = IDLE_MAX;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int find_channel(input logic [ppwm_pkg::PORT_W-1:0] port,
                                       input logic [ppwm_pkg::BIT_W-1:0] bit_sel);
      for (int k = 0; k < NCH; k++)
         if (chan_bound[k] && chan_port[k] == port && chan_bit[k] == bit_sel)
            return k;
      return -1;
   endfunction

   function automatic probe_rsp_type meter_predict(input probe_cmd_type c);
      probe_rsp_type r;
      logic lvl;
      logic [ppwm_pkg::TICKS_W-1:0] run;
      int hit;
      r = '0;
      case (c.command)
         ppwm_pkg::CMD_SAMPLE: begin
            r.ok = 1'b1;
            for (int k = 0; k < NCH; k++) begin
               if (chan_bound[k]) begin
                  lvl = c.port_snapshot[{chan_port[k], chan_bit[k]}];
                  run = (chan_count[k] == '1) ? chan_count[k] : chan_count[k] + 1'b1;
                  if (lvl && !chan_level[k]) begin
                     chan_low[k]    = run;
                     chan_count[k]  = '0;
                     r.rise_mask[k] = 1'b1;
                  end else if (!lvl && chan_level[k]) begin
                     chan_high[k]   = run;
                     chan_count[k]  = '0;
                     r.fall_mask[k] = 1'b1;
                  end else begin
                     chan_count[k] = run;
                  end
                  chan_level[k] = lvl;
               end
            end
         end
         ppwm_pkg::CMD_SET: begin
            if (find_channel(c.port_index, c.bit_index) < 0) begin
               hit = -1;
               for (int k = NCH - 1; k >= 0; k--)
                  if (!chan_bound[k]) hit = k;
               if (hit >= 0) begin
                  chan_bound[hit] = 1'b1;
                  chan_port[hit]  = c.port_index;
                  chan_bit[hit]   = c.bit_index;
                  chan_level[hit] = 1'b0;
                  chan_count[hit] = '0;
                  chan_high[hit]  = '0;
                  chan_low[hit]   = '0;
                  r.ok      = 1'b1;
                  r.channel = hit[ppwm_pkg::CHIDX_W-1:0];
               end
            end
         end
         ppwm_pkg::CMD_DELETE: begin
            hit = find_channel(c.port_index, c.bit_index);
            if (hit >= 0) begin
               chan_bound[hit] = 1'b0;   // history stays
               r.ok      = 1'b1;
               r.channel = hit[ppwm_pkg::CHIDX_W-1:0];
            end
         end
         ppwm_pkg::CMD_FIND: begin
            hit = find_channel(c.port_index, c.bit_index);
            if (hit >= 0) begin
               r.ok      = 1'b1;
               r.channel = hit[ppwm_pkg::CHIDX_W-1:0];
            end
         end
         ppwm_pkg::CMD_READ: begin
            r.ok         = 1'b1;
            r.channel    = c.channel_index;
            r.high_ticks = chan_high[c.channel_index];
            r.low_ticks  = chan_low[c.channel_index];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic probe_rsp_type rsp(input int ok, input int ch, input int hi, input int lo,
                                         input int rise, input int fall);
      probe_rsp_type r;
      r.ok         = ok[0];
      r.channel    = ch[ppwm_pkg::CHIDX_W-1:0];
      r.high_ticks = hi;
      r.low_ticks  = lo;
      r.rise_mask  = rise[ppwm_pkg::MASK_W-1:0];
      r.fall_mask  = fall[ppwm_pkg::MASK_W-1:0];
      return r;
   endfunction

   function automatic void add_row(input logic [ppwm_pkg::CMD_W-1:0] cmd, input int port,
                                   input int bit_sel, input int chan,
                                   input logic [ppwm_pkg::SNAP_W-1:0] snap,
                                   input logic fixed = 1'b0, input probe_rsp_type exp = '0);
      script_row_type row;
      row.cmd.command       = cmd;
      row.cmd.port_index    = port[ppwm_pkg::PORT_W-1:0];
      row.cmd.bit_index     = bit_sel[ppwm_pkg::BIT_W-1:0];
      row.cmd.channel_index = chan[ppwm_pkg::CHIDX_W-1:0];
      row.cmd.port_snapshot = snap;
      row.fixed             = fixed;
      row.rsp               = exp;
      script.push_back(row);
   endfunction

   function automatic int pick_bound();
      int list[$];
      for (int k = 0; k < NCH; k++)
         if (chan_bound[k]) list.push_back(k);
      if (list.size() == 0) return -1;
      return list[$urandom_range(0, list.size() - 1)];
   endfunction

   // snapshot stream with held levels, so widths vary
   function automatic logic [ppwm_pkg::SNAP_W-1:0] next_wave();
      int roll;
      int k;
      roll = $urandom_range(0, 99);
      k = pick_bound();
      if (roll >= 65 && roll < 90 && k >= 0)
         wave[{chan_port[k], chan_bit[k]}] = ~wave[{chan_port[k], chan_bit[k]}];
      else if (roll >= 90 && roll < 96)
         wave = wave ^ (32'd1 << $urandom_range(0, ppwm_pkg::SNAP_W - 1));
      else if (roll >= 96)
         wave = $urandom;
      return wave;
   endfunction

   function automatic probe_cmd_type random_cmd();
      probe_cmd_type c;
      logic [31:0] rnd;
      int roll;
      int k;
      rnd = $urandom;
      c.command       = ppwm_pkg::CMD_SAMPLE;
      c.port_index    = rnd[ppwm_pkg::PORT_W-1:0];
      c.bit_index     = rnd[ppwm_pkg::PORT_W +: ppwm_pkg::BIT_W];
      c.channel_index = rnd[ppwm_pkg::PORT_W + ppwm_pkg::BIT_W +: ppwm_pkg::CHIDX_W];
      c.port_snapshot = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
         c.port_snapshot = next_wave();
      end else if (roll < 68) begin
         c.command = ppwm_pkg::CMD_SET;
      end else if (roll < 76) begin
         c.command = ppwm_pkg::CMD_DELETE;
      end else if (roll < 84) begin
         c.command = ppwm_pkg::CMD_FIND;
      end else if (roll < 95) begin
         c.command = ppwm_pkg::CMD_READ;
      end else begin
         case ($urandom_range(0, 2))
            0: c.command = CMD_RSVD5;
            1: c.command = CMD_RSVD6;
            default: c.command = CMD_RSVD7;
         endcase
      end
      // aim most lookups at bound pairs; sets mostly new pairs
      if (c.command == ppwm_pkg::CMD_SET || c.command == ppwm_pkg::CMD_DELETE
          || c.command == ppwm_pkg::CMD_FIND) begin
         k = pick_bound();
         if (k >= 0 && $urandom_range(0, 3) < ((c.command == ppwm_pkg::CMD_SET) ? 1 : 3))
         begin
            c.port_index = chan_port[k];
            c.bit_index  = chan_bit[k];
         end
      end
      return c;
   endfunction

   task automatic push_cmd(input probe_cmd_type c, input logic fixed,
                           input probe_rsp_type exp);
      int gap;
      probe_rsp_type want;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= c.command;
      req_ch.port_index    <= c.port_index;
      req_ch.bit_index     <= c.bit_index;
      req_ch.channel_index <= c.channel_index;
      req_ch.port_snapshot <= c.port_snapshot;
      do @(posedge clock); while (!req_ch.ready);
      want = meter_predict(c);
      pending_rsp.push_back(fixed ? exp : want);
   endtask

   // hold off the request side until every result is back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic field_check(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         fail_count++;
      end
   endtask

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   always @(posedge clock) begin : rsp_monitor
      probe_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result transfer with no command outstanding");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            field_check("ok", 32'(want.ok), 32'(rsp_ch.ok));
            field_check("channel", 32'(want.channel), 32'(rsp_ch.channel));
            field_check("high_ticks", want.high_ticks, rsp_ch.high_ticks);
            field_check("low_ticks", want.low_ticks, rsp_ch.low_ticks);
            field_check("rise_mask", 32'(want.rise_mask), 32'(rsp_ch.rise_mask));
            field_check("fall_mask", 32'(want.fall_mask), 32'(rsp_ch.fall_mask));
         end
      end
   end

   initial begin
      probe_cmd_type c;
      req_ch.valid         <= 1'b0;
      req_ch.command       <= ppwm_pkg::CMD_SAMPLE;
      req_ch.port_index    <= '0;
      req_ch.bit_index     <= '0;
      req_ch.channel_index <= '0;
      req_ch.port_snapshot <= '0;

      // empty table after reset
      add_row(ppwm_pkg::CMD_READ,   0, 0, 0, 32'h0,        1'b1, rsp(1, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_READ,   0, 0, 3, 32'hFFFFFFFF, 1'b1, rsp(1, 3, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_FIND,   3, 7, 0, 32'h0,        1'b1, rsp(0, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_DELETE, 0, 0, 0, 32'h0,        1'b1, rsp(0, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SAMPLE, 0, 0, 0, 32'hFFFFFFFF, 1'b1, rsp(1, 0, 0, 0, 0, 0));
      // fill all channels, with a duplicate pair on the way, then table full
      add_row(ppwm_pkg::CMD_SET,    0, 0, 0, 32'h0,        1'b1, rsp(1, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SET,    3, 7, 0, 32'h0,        1'b1, rsp(1, 1, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SET,    0, 0, 0, 32'h0,        1'b1, rsp(0, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SET,    1, 4, 0, 32'h0,        1'b1, rsp(1, 2, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SET,    2, 2, 0, 32'h0,        1'b1, rsp(1, 3, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SET,    3, 0, 0, 32'h0,        1'b1, rsp(0, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_FIND,   3, 7, 0, 32'h0,        1'b1, rsp(1, 1, 0, 0, 0, 0));
      // rise, hold, fall on every channel: low 1 tick, high 2 ticks
      add_row(ppwm_pkg::CMD_SAMPLE, 0, 0, 0, 32'hFFFFFFFF, 1'b1, rsp(1, 0, 0, 0, 4'hF, 0));
      add_row(ppwm_pkg::CMD_SAMPLE, 0, 0, 0, 32'hFFFFFFFF, 1'b1, rsp(1, 0, 0, 0, 0, 0));
      add_row(ppwm_pkg::CMD_SAMPLE, 0, 0, 0, 32'h0,        1'b1, rsp(1, 0, 0, 0, 0, 4'hF));
      add_row(ppwm_pkg::CMD_READ,   0, 0, 1, 32'h0,        1'b1, rsp(1, 1, 2, 1, 0, 0));
      // delete keeps history; a new set clears it
      add_row(ppwm_pkg::CMD_SAMPLE, 0, 0, 0, 32'h80000001);
      add_row(ppwm_pkg::CMD_DELETE, 3, 7, 0, 32'h0);
      add_row(ppwm_pkg::CMD_SAMPLE, 0, 0, 0, 32'h0);
      add_row(ppwm_pkg::CMD_READ,   0, 0, 1, 32'h0);
      add_row(ppwm_pkg::CMD_SET,    1, 1, 0, 32'h0);
      add_row(ppwm_pkg::CMD_READ,   0, 0, 1, 32'h0,        1'b1, rsp(1, 1, 0, 0, 0, 0));
      // unused codes do nothing
      add_row(CMD_RSVD5,  3, 7, 3, 32'hFFFFFFFF, 1'b1, rsp(0, 0, 0, 0, 0, 0));
      add_row(CMD_RSVD6,  2, 5, 2, 32'hA5A5A5A5, 1'b1, rsp(0, 0, 0, 0, 0, 0));
      add_row(CMD_RSVD7,  1, 2, 1, 32'h5A5A5A5A, 1'b1, rsp(0, 0, 0, 0, 0, 0));

      do @(posedge clock); while (reset);

      foreach (script[i])
         push_cmd(script[i].cmd, script[i].fixed, script[i].rsp);
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            send_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
            rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
         end
         if (n == RANDOM_ITEMS / 2)
            wait_for_drain();
         c = random_cmd();
         push_cmd(c, 1'b0, '0);
      end

      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
